### src/vfu_pkg.sv
// ----------------------------------------------------------------------------
// vfu_pkg
// Shared types and constants for the voxel scale, clamp and mirror core.
// ----------------------------------------------------------------------------
package vfu_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int SIZE_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int SAMPLE_W    = 32;
  localparam int IDX_W       = 30;
  localparam int WORD_W      = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_UNF  = 2'd1,
    CLS_OVF  = 2'd2,
    CLS_NUM  = 2'd3
  } val_cls_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]    idx;
    logic                last;
  } vox_t;

endpackage

### src/vfu_front.sv
// ----------------------------------------------------------------------------
// vfu_front
// Accepts voxels, tracks the x/y/z position and computes the mirrored
// destination index through a short multiply pipeline.
// ----------------------------------------------------------------------------
module vfu_front #(
  parameter int MAX_DIM = vfu_pkg::MAX_DIM_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vfu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vfu_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vfu_pkg::SAMPLE_W-1:0] in_sample_i,
  output logic                         push_o,
  output vfu_pkg::vox_t                push_data_o,
  input  logic                         full_i
);
  import vfu_pkg::*;

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int PW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SUM_W = 3 * DW + 1;

  function automatic logic [DW-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) w = 32'd1;
    else if (w > 32'(MAX_DIM)) w = 32'(MAX_DIM);
    return DW'(w);
  endfunction

  logic [DW-1:0] nx_q, ny_q, nz_q;
  logic [PW-1:0] px_q, py_q, pz_q;
  logic          en, acc, cfg_hit;
  logic          x_end, y_end, z_end;

  logic              a_v_q, b_v_q, c_v_q;
  logic [SAMPLE_W-1:0] a_s_q, b_s_q, c_s_q;
  logic              a_l_q, b_l_q, c_l_q;
  logic [DW-1:0]     a_x_q, a_ry_q, a_rz_q, a_nx_q, a_ny_q;
  logic [DW-1:0]     b_x_q, b_rz_q;
  logic [2*DW-1:0]   b_row_q, b_nxny_q;
  logic [2*DW:0]     c_part_q;
  logic [3*DW-1:0]   c_plane_q;

  assign en         = !c_v_q || !full_i;
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;
  assign cfg_hit    = cfg_we_i && (cfg_idx_i == REG_SIZE_X || cfg_idx_i == REG_SIZE_Y ||
                                   cfg_idx_i == REG_SIZE_Z);

  assign x_end = (DW'(px_q) == nx_q - DW'(1));
  assign y_end = (DW'(py_q) == ny_q - DW'(1));
  assign z_end = (DW'(pz_q) == nz_q - DW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= DW'(1);
      ny_q <= DW'(1);
      nz_q <= DW'(1);
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        REG_SIZE_X: nx_q <= eff_size(cfg_wdata_i);
        REG_SIZE_Y: ny_q <= eff_size(cfg_wdata_i);
        REG_SIZE_Z: nz_q <= eff_size(cfg_wdata_i);
        default: ;
      endcase
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (acc) begin
      if (!x_end) begin
        px_q <= px_q + PW'(1);
      end else begin
        px_q <= '0;
        if (!y_end) begin
          py_q <= py_q + PW'(1);
        end else begin
          py_q <= '0;
          pz_q <= z_end ? '0 : pz_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_s_q     <= in_sample_i;
      a_l_q     <= x_end && y_end && z_end;
      a_x_q     <= DW'(px_q);
      a_ry_q    <= ny_q - DW'(1) - DW'(py_q);
      a_rz_q    <= nz_q - DW'(1) - DW'(pz_q);
      a_nx_q    <= nx_q;
      a_ny_q    <= ny_q;
      b_s_q     <= a_s_q;
      b_l_q     <= a_l_q;
      b_x_q     <= a_x_q;
      b_rz_q    <= a_rz_q;
      b_row_q   <= (2*DW)'(a_ry_q) * (2*DW)'(a_nx_q);
      b_nxny_q  <= (2*DW)'(a_nx_q) * (2*DW)'(a_ny_q);
      c_s_q     <= b_s_q;
      c_l_q     <= b_l_q;
      c_part_q  <= (2*DW+1)'(b_x_q) + (2*DW+1)'(b_row_q);
      c_plane_q <= (3*DW)'(b_rz_q) * (3*DW)'(b_nxny_q);
    end
  end

  assign push_o             = c_v_q && !full_i;
  assign push_data_o.sample = c_s_q;
  assign push_data_o.last   = c_l_q;
  assign push_data_o.idx    = IDX_W'(SUM_W'(c_part_q) + SUM_W'(c_plane_q));

endmodule

### src/vfu_queue.sv
// ----------------------------------------------------------------------------
// vfu_queue
// Small FIFO that decouples index generation from the value datapath.
// ----------------------------------------------------------------------------
module vfu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vfu_pkg::vox_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output vfu_pkg::vox_t head_o
);
  import vfu_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  vox_t          mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (pop_i)  rp_q <= rp_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (AW+1)'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

### src/vfu_back.sv
// ----------------------------------------------------------------------------
// vfu_back
// Multiplies by ten with nearest-even rounding, clamps, rounds half-up to
// an unsigned word, byte-swaps and drives the output register.
// ----------------------------------------------------------------------------
module vfu_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  vfu_pkg::vox_t              head_i,
  output logic                       pop_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [vfu_pkg::IDX_W-1:0]  idx_o,
  output logic [vfu_pkg::WORD_W-1:0] word_o,
  output logic                       ovf_o,
  output logic                       unf_o,
  output logic                       last_o
);
  import vfu_pkg::*;

  logic        en;
  logic        sgn, is_nan, is_inf;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [23:0] mant, keep;
  logic [27:0] prod;
  logic        g, rest, rup;
  logic [24:0] m_d;
  logic signed [9:0] k_d;
  val_cls_e    cls_d;

  logic              r_v_q;
  logic [24:0]       r_m_q;
  logic signed [9:0] r_k_q;
  val_cls_e          r_cls_q;
  logic [IDX_W-1:0]  r_idx_q;
  logic              r_l_q;

  logic              big;
  logic [9:0]        s;
  logic [25:0]       rnd;
  logic [31:0]       w;

  assign en    = !m_tvalid_o || m_tready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    sgn    = head_i.sample[31];
    ex     = head_i.sample[30:23];
    fr     = head_i.sample[22:0];
    mant   = {1'b1, fr};
    prod   = (28'(mant) << 3) + (28'(mant) << 1);
    if (prod[27]) begin
      keep = prod[27:4];
      g    = prod[3];
      rest = |prod[2:0];
      k_d  = $signed({2'b00, ex}) - 10'sd146;
    end else begin
      keep = prod[26:3];
      g    = prod[2];
      rest = |prod[1:0];
      k_d  = $signed({2'b00, ex}) - 10'sd147;
    end
    rup    = g && (rest || keep[0]);
    m_d    = 25'(keep) + 25'(rup);
    is_nan = (ex == 8'hff) && (fr != '0);
    is_inf = (ex == 8'hff) && (fr == '0);
    if (is_nan)                                 cls_d = CLS_UNF;
    else if (sgn && (ex != '0 || fr != '0))     cls_d = CLS_UNF;
    else if (ex == '0)                          cls_d = CLS_ZERO;
    else if (is_inf)                            cls_d = CLS_OVF;
    else                                        cls_d = CLS_NUM;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_m_q   <= m_d;
      r_k_q   <= k_d;
      r_cls_q <= cls_d;
      r_idx_q <= head_i.idx;
      r_l_q   <= head_i.last;
    end
  end

  always_comb begin
    big = (r_k_q >= 10'sd9) || (r_k_q == 10'sd8 && r_m_q[24]);
    s   = 10'(-r_k_q);
    rnd = '0;
    w   = '0;
    if (r_k_q >= 10'sd0) begin
      w = 32'(r_m_q) << r_k_q[3:0];
    end else if (s <= 10'd25) begin
      rnd = 26'(r_m_q) + (26'd1 << (s[4:0] - 5'd1));
      w   = 32'(rnd >> s[4:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q      <= 1'b0;
      m_tvalid_o <= 1'b0;
    end else if (en) begin
      r_v_q      <= !empty_i;
      m_tvalid_o <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_o  <= r_idx_q;
      last_o <= r_l_q;
      case (r_cls_q)
        CLS_UNF: begin
          word_o <= '0;
          ovf_o  <= 1'b0;
          unf_o  <= 1'b1;
        end
        CLS_OVF: begin
          word_o <= '1;
          ovf_o  <= 1'b1;
          unf_o  <= 1'b0;
        end
        CLS_NUM: begin
          word_o <= big ? '1 : {w[7:0], w[15:8], w[23:16], w[31:24]};
          ovf_o  <= big;
          unf_o  <= 1'b0;
        end
        default: begin
          word_o <= '0;
          ovf_o  <= 1'b0;
          unf_o  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### src/voxel_float_to_uint_flip_core.sv
// ----------------------------------------------------------------------------
// voxel_float_to_uint_flip_core
// Scales single-precision voxels by ten, clamps and rounds them to byte-swapped
// unsigned words, and tags each with its y/z-mirrored destination index.
// ----------------------------------------------------------------------------
// One voxel per cycle sustained while the queue has room, x fastest, then y,
// then z. An input transaction passes the index multiply pipeline stages
// a, b and c, the queue, a register after multiply-by-ten and rounding, and
// the output register after clamping. The four-entry queue lets either side
// stall independently. Writing any size register restarts the volume at the
// origin; a size of 0 acts as 1, a size above MAX_DIM acts as MAX_DIM.
module voxel_float_to_uint_flip_core #(
  parameter int MAX_DIM = vfu_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vfu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vfu_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [31:0] sample_bits
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // [29:0] dest_index, [61:30] out_word
  output logic [1:0]                    m_axis_tuser,   // [0] overflow, [1] underflow
  output logic                          m_axis_tlast
);
  import vfu_pkg::*;

  logic             push, full, pop, empty, ovf, unf;
  vox_t             push_data, head;
  logic [IDX_W-1:0] idx;
  logic [WORD_W-1:0] word;

  vfu_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  vfu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  vfu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .idx_o      (idx),
    .word_o     (word),
    .ovf_o      (ovf),
    .unf_o      (unf),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, word, idx};
  assign m_axis_tuser = {unf, ovf};

endmodule

### tb/voxel_flip_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_flip_checker
// Watches the config port and both streams of the voxel flip core, predicts
// each output transaction from the accepted samples and compares field by
// field. The single-precision scale by ten is modeled in integer arithmetic.
// ----------------------------------------------------------------------------
module voxel_flip_checker #(
  parameter int MAX_DIM = vfu_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vfu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vfu_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [63:0]                   m_axis_tdata,
  input  logic [1:0]                    m_axis_tuser,
  input  logic                          m_axis_tlast,
  output int                            pending_o,
  output int                            errors_o,
  output int                            results_o,
  output int                            ovf_seen_o,
  output int                            unf_seen_o,
  output int                            last_seen_o
);
  import vfu_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              ovf;
    logic              unf;
    logic              last;
  } voxel_out_t;

  voxel_out_t expected_q[$];
  logic [SIZE_W-1:0] dim_reg [3];
  int unsigned cnt_x, cnt_y, cnt_z;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // scaled value as (ovf, unf, word); word is floor(|p| + 0.5) with clamps
  function automatic voxel_out_t scale_sample(logic [31:0] bits);
    voxel_out_t r;
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    longint      prod, q, rem, half;
    int          e2, msb, shift, xp;
    sgn = bits[31];
    ex = bits[30:23];
    man = bits[22:0];
    r.ovf = 0;
    r.unf = 0;
    r.word = '0;
    if (ex == 8'hFF) begin
      if (man != 0 || sgn) r.unf = 1;
      else begin
        r.ovf = 1;
        r.word = '1;
      end
      return r;
    end
    if (ex == 0 && man == 0) return r;
    if (sgn) begin
      r.unf = 1;
      return r;
    end
    if (ex == 0) begin
      prod = longint'(man) * 10;
      e2 = -149;
    end else begin
      prod = longint'({1'b1, man}) * 10;
      e2 = int'(ex) - 150;
    end
    msb = 0;
    for (int i = 0; i < 40; i++) if (prod[i]) msb = i;
    shift = msb - 23;
    if (-149 - e2 > shift) shift = -149 - e2;
    q = prod;
    if (shift > 0) begin
      q = prod >> shift;
      rem = prod & ((longint'(1) << shift) - 1);
      half = longint'(1) << (shift - 1);
      if (rem > half || (rem == half && q[0])) q++;
      xp = e2 + shift;
    end else xp = e2;
    if (xp >= 0) begin
      if (xp >= 32 || (q << xp) >= 64'h1_0000_0000) begin
        r.ovf = 1;
        r.word = '1;
      end else r.word = WORD_W'(q << xp);
    end else if (-xp < 40) begin
      r.word = WORD_W'((q + (longint'(1) << (-xp - 1))) >> (-xp));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    voxel_out_t e;
    int unsigned nx, ny, nz;
    if (!rst_ni) begin
      dim_reg[0] <= 1;
      dim_reg[1] <= 1;
      dim_reg[2] <= 1;
      cnt_x = 0;
      cnt_y = 0;
      cnt_z = 0;
      expected_q.delete();
      pending_o <= 0;
      errors_o = 0;
      results_o = 0;
      ovf_seen_o = 0;
      unf_seen_o = 0;
      last_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SIZE_X: dim_reg[0] <= cfg_wdata_i;
          REG_SIZE_Y: dim_reg[1] <= cfg_wdata_i;
          REG_SIZE_Z: dim_reg[2] <= cfg_wdata_i;
          default: ;
        endcase
        if (cfg_reg_e'(cfg_idx_i) inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z}) begin
          cnt_x = 0;
          cnt_y = 0;
          cnt_z = 0;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        nx = clamp_dim(dim_reg[0]);
        ny = clamp_dim(dim_reg[1]);
        nz = clamp_dim(dim_reg[2]);
        e = scale_sample(s_axis_tdata);
        e.word = {e.word[7:0], e.word[15:8], e.word[23:16], e.word[31:24]};
        e.idx = IDX_W'(longint'(cnt_x) + longint'(ny - 1 - cnt_y) * nx
                       + longint'(nz - 1 - cnt_z) * nx * ny);
        e.last = (cnt_x == nx - 1 && cnt_y == ny - 1 && cnt_z == nz - 1);
        expected_q.push_back(e);
        if (cnt_x + 1 < nx) cnt_x++;
        else begin
          cnt_x = 0;
          if (cnt_y + 1 < ny) cnt_y++;
          else begin
            cnt_y = 0;
            cnt_z = (cnt_z + 1 < nz) ? cnt_z + 1 : 0;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: output transaction with nothing expected", $realtime);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[29:0] !== e.idx) report_mismatch("dest_index", m_axis_tdata[29:0], e.idx);
          if (m_axis_tdata[61:30] !== e.word) report_mismatch("out_word", m_axis_tdata[61:30], e.word);
          if (m_axis_tdata[63:62] !== 2'b00) report_mismatch("tdata pad", m_axis_tdata[63:62], 0);
          if (m_axis_tuser[0] !== e.ovf) report_mismatch("overflow", m_axis_tuser[0], e.ovf);
          if (m_axis_tuser[1] !== e.unf) report_mismatch("underflow", m_axis_tuser[1], e.unf);
          if (m_axis_tlast !== e.last) report_mismatch("last_voxel", m_axis_tlast, e.last);
          ovf_seen_o += e.ovf;
          unf_seen_o += e.unf;
          last_seen_o += e.last;
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives volumes of single-precision voxels through the flip core under
// several size settings and handshake idling patterns, with a long output
// stall; the checker predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module testbench;
  import vfu_pkg::*;

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [63:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  int pending, errors, results, ovf_seen, unf_seen, last_seen;
  int send_idle_pct, recv_idle_pct;
  logic hold_req = 0;
  logic hold_active;

  voxel_float_to_uint_flip_core DUT (.*);

  voxel_flip_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .pending_o(pending), .errors_o(errors), .results_o(results),
    .ovf_seen_o(ovf_seen), .unf_seen_o(unf_seen), .last_seen_o(last_seen)
  );

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    hold_active = 0;
    wait (hold_req);
    hold_active = 1;
    repeat (80) @(posedge clk_i);
    hold_active = 0;
  end

  always @(posedge clk_i) begin
    if (hold_active) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic write_size(cfg_reg_e which, logic [SIZE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= which;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic resize(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy, logic [SIZE_W-1:0] sz);
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    write_size(REG_SIZE_X, sx);
    write_size(REG_SIZE_Y, sy);
    write_size(REG_SIZE_Z, sz);
  endtask

  task automatic send_voxel(logic [31:0] bits);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= bits;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_sample();
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0000, 32'h3F00_0000, 32'h4F80_0000, 32'h0000_0001};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return {1'b0, 8'($urandom_range(110, 160)), 23'($urandom)};
      7:          return {1'b1, 8'($urandom_range(110, 160)), 23'($urandom)};
      8:          return specials[$urandom_range(0, 7)];
      default:    return {1'b0, 8'($urandom_range(154, 156)), 23'($urandom)};
    endcase
  endfunction

  task automatic idle_end();
    s_axis_tvalid <= 0;
  endtask

  initial begin
    static logic [31:0] directed [18] = '{
      32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
      32'hFFFF_FFFF, 32'h0000_0001, 32'h3F00_0000, 32'h3DCC_CCCD, 32'h4F80_0000,
      32'h4E4C_CCCC, 32'h3C23_D70A, 32'h3D4C_CCCD, 32'h7F7F_FFFF, 32'hBF80_0000,
      32'h3F80_0000, 32'h7FFF_FFFF, 32'h4E4C_CCCD};
    send_idle_pct = 31;
    recv_idle_pct = 69;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    resize(3, 2, 1);
    foreach (directed[i]) send_voxel(directed[i]);
    idle_end();
    resize(0, 2047, 1);
    repeat (6) send_voxel(random_sample());
    idle_end();
    resize(1024, 1024, 1024);
    repeat (5) send_voxel(random_sample());
    idle_end();

    resize(4, 3, 2);
    hold_req = 1;
    repeat (120) send_voxel(random_sample());
    idle_end();
    send_idle_pct = 69;
    recv_idle_pct = 31;
    resize(2, 2, 3);
    repeat (120) send_voxel(random_sample());
    idle_end();
    resize(5, 1, 3);
    repeat (120) send_voxel(random_sample());
    idle_end();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    resize(7, 3, 2);
    repeat (120) send_voxel(random_sample());
    idle_end();

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d voxels over 7 volume shapes and three idling patterns,", results);
    $display("with %0d saturated, %0d forced to zero and %0d end-of-volume marks.",
             ovf_seen, unf_seen, last_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
